// ===== design/safa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safa_pkg: shared types and constants for the slot admission arbiter
// Result codes, controller states and controller/datapath command structs.
// ----------------------------------------------------------------------------
package safa_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int WAIT_DEPTH_DEF = 16;
	localparam int ID_WIDTH_DEF   = 8;
	localparam logic [3:0] MAX_SLOTS_RESET = 4'd4;

	typedef enum logic [2:0] {
		KIND_GRANTED     = 3'd0,
		KIND_QUEUED      = 3'd1,
		KIND_DUPLICATE   = 3'd2,
		KIND_WAIT_FULL   = 3'd3,
		KIND_REL_PROMOTE = 3'd4,
		KIND_REL_PLAIN   = 3'd5
	} kind_t;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SHIFT,
		ST_PROMOTE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;        // capture the input item
		logic search;      // run the id match against both sets
		logic decide;      // apply request or release removal
		logic shift_step;  // move the wait list one entry toward the head
		logic promote;     // move the head of the wait list into a slot
		logic emit;        // load the output register
	} cmd_t;

	typedef struct packed {
		logic shift_busy;  // compaction still has entries to move
		logic can_promote; // a slot is free under the limit and clients wait
		logic is_release;  // the captured item is a release
	} status_t;

endpackage

// ===== design/safa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safa_datapath: slot table, wait list and result registers
// Holds the active set and the ordered wait list; compacts the wait list one
// entry per cycle after a removal.
// ----------------------------------------------------------------------------
module safa_datapath
	import safa_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
	parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [3:0]          max_slots,
	input  logic                in_op,
	input  logic [ID_WIDTH-1:0] in_id,
	output kind_t               res_kind,
	output logic [7:0]          res_target,
	output logic                res_perm,
	output logic [3:0]          res_active,
	output logic [4:0]          res_waiting
);

	localparam int SW = $clog2(SLOT_COUNT + 1);
	localparam int WW = $clog2(WAIT_DEPTH + 1);
	localparam int WI = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int SI = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [ID_WIDTH-1:0] active_ids_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] active_valid_q;
	logic [ID_WIDTH-1:0] wait_ids_q [WAIT_DEPTH];
	logic [WW-1:0] wait_count_q;
	logic op_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [SLOT_COUNT-1:0] act_hit_q;
	logic [WAIT_DEPTH-1:0] wait_hit_q;
	logic [WW-1:0] shift_pos_q;
	logic shift_busy_q;
	kind_t kind_q;
	logic [ID_WIDTH-1:0] target_q;
	logic perm_q;

	logic [SW-1:0] held;
	logic [SW-1:0] limit;
	logic [SI-1:0] free_idx;
	logic [WI-1:0] hit_pos;
	logic any_act_hit, any_wait_hit;

	always_comb begin
		held = '0;
		for (int i = 0; i < SLOT_COUNT; i++) held = held + SW'(active_valid_q[i]);
	end

	always_comb begin
		if ({28'd0, max_slots} > SLOT_COUNT) limit = SW'(SLOT_COUNT);
		else limit = SW'(max_slots);
	end

	always_comb begin
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--)
			if (!active_valid_q[i]) free_idx = SI'(i);
	end

	always_comb begin
		hit_pos = '0;
		for (int i = WAIT_DEPTH - 1; i >= 0; i--)
			if (wait_hit_q[i]) hit_pos = WI'(i);
	end

	assign any_act_hit  = |act_hit_q;
	assign any_wait_hit = |wait_hit_q;
	assign status.shift_busy  = shift_busy_q;
	assign status.can_promote = (held < limit) && (wait_count_q != '0);
	assign status.is_release  = (op_q == OP_RELEASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_valid_q <= '0;
			wait_count_q   <= '0;
			shift_pos_q    <= '0;
			shift_busy_q   <= 1'b0;
		end else begin
			if (cmd.decide) begin
				if (op_q == OP_REQUEST) begin
					if (!any_act_hit && !any_wait_hit) begin
						if (held < limit) begin
							active_valid_q[free_idx] <= 1'b1;
						end else if (wait_count_q < WW'(WAIT_DEPTH)) begin
							wait_count_q <= wait_count_q + 1'b1;
						end
					end
				end else begin
					active_valid_q <= active_valid_q & ~act_hit_q;
					if (any_wait_hit) begin
						shift_pos_q  <= WW'(hit_pos);
						shift_busy_q <= 1'b1;
					end
				end
			end
			if (cmd.shift_step) begin
				if (shift_pos_q + 1'b1 >= wait_count_q) begin
					shift_busy_q <= 1'b0;
					wait_count_q <= wait_count_q - 1'b1;
				end else begin
					shift_pos_q <= shift_pos_q + 1'b1;
				end
			end
			if (cmd.promote) begin
				active_valid_q[free_idx] <= 1'b1;
				if (wait_count_q > 1) begin
					shift_pos_q  <= '0;
					shift_busy_q <= 1'b1;
				end else begin
					wait_count_q <= '0;
				end
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			id_q <= in_id;
		end
		if (cmd.search) begin
			for (int i = 0; i < SLOT_COUNT; i++)
				act_hit_q[i] <= active_valid_q[i] && (active_ids_q[i] == id_q);
			for (int i = 0; i < WAIT_DEPTH; i++)
				wait_hit_q[i] <= (WW'(i) < wait_count_q) && (wait_ids_q[i] == id_q);
		end
		if (cmd.decide) begin
			target_q <= id_q;
			perm_q   <= 1'b0;
			if (op_q == OP_REQUEST) begin
				if (any_act_hit || any_wait_hit) begin
					kind_q <= KIND_DUPLICATE;
				end else if (held < limit) begin
					active_ids_q[free_idx] <= id_q;
					kind_q <= KIND_GRANTED;
					perm_q <= 1'b1;
				end else if (wait_count_q < WW'(WAIT_DEPTH)) begin
					wait_ids_q[wait_count_q[WI-1:0]] <= id_q;
					kind_q <= KIND_QUEUED;
				end else begin
					kind_q <= KIND_WAIT_FULL;
				end
			end else begin
				kind_q <= KIND_REL_PLAIN;
			end
		end
		if (cmd.shift_step && (shift_pos_q + 1'b1 < wait_count_q))
			wait_ids_q[shift_pos_q[WI-1:0]] <= wait_ids_q[shift_pos_q[WI-1:0] + 1'b1];
		if (cmd.promote) begin
			active_ids_q[free_idx] <= wait_ids_q[0];
			target_q <= wait_ids_q[0];
			kind_q   <= KIND_REL_PROMOTE;
			perm_q   <= 1'b1;
		end
		if (cmd.emit) begin
			res_kind    <= kind_q;
			res_target  <= 8'(target_q);
			res_perm    <= perm_q;
			res_active  <= 4'(held);
			res_waiting <= 5'(wait_count_q);
		end
	end

endmodule

// ===== design/safa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safa_ctrl: sequencing of one item through the datapath
// Accepts an item, searches, decides, compacts, promotes, then offers the
// result; the next item is taken while the result register still waits.
// ----------------------------------------------------------------------------
module safa_ctrl
	import safa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t status
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   phase_q; // 0: compaction after removal, 1: after promotion

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else begin
			if (cmd.decide) phase_q <= 1'b0;
			if (cmd.promote) phase_q <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				state_d    = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_SHIFT;
			end
			ST_SHIFT: begin
				// Only a release may promote a waiting client.
				if (status.shift_busy) begin
					cmd.shift_step = 1'b1;
				end else if (!phase_q && status.can_promote && status.is_release) begin
					state_d = ST_PROMOTE;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_PROMOTE: begin
				cmd.promote = 1'b1;
				state_d     = ST_SHIFT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== design/slot_admission_fifo_arbiter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_admission_fifo_arbiter_top: slot admission with a FIFO wait list
// Grants up to max_slots clients a slot, queues the rest in arrival order.
// ----------------------------------------------------------------------------
// An item is accepted only while the controller is idle. It then passes
// through the search, decide and shift states to the output state, which
// loads its result into the output register and returns to idle, where the
// next item can be accepted. Removing a waiting client makes the wait list
// compact from it to the tail, one entry per cycle. A promotion moves the
// head of the wait list into a slot and, when more than one waits, compacts
// the rest. The result sits in an output register, so the next item is
// accepted while it waits; a newer result is held back until the old one is
// taken. A request is checked against both the slot holders and the wait
// list, and a match returns duplicate-ignored.
module slot_admission_fifo_arbiter_top
	import safa_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
	parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [0] operation, [8:1] client_id, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [2:0] result_kind, [10:3] target_id,
	                              // [11] permission, [15:12] active_count,
	                              // [20:16] waiting_count, rest zero
);

	cmd_t    cmd;
	status_t status;
	logic [3:0] max_slots_q;
	kind_t res_kind;
	logic [7:0] res_target;
	logic res_perm;
	logic [3:0] res_active;
	logic [4:0] res_waiting;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_slots_q <= MAX_SLOTS_RESET;
		else if (cfg_valid && cfg_ready) max_slots_q <= cfg_data;
	end

	safa_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cmd, .status
	);

	safa_datapath #(
		.SLOT_COUNT(SLOT_COUNT), .WAIT_DEPTH(WAIT_DEPTH), .ID_WIDTH(ID_WIDTH)
	) u_dp (
		.clk, .arst_n, .cmd, .status,
		.max_slots(max_slots_q),
		.in_op(s_tdata[0]),
		.in_id(s_tdata[ID_WIDTH:1]),
		.res_kind, .res_target, .res_perm, .res_active, .res_waiting
	);

	assign m_tdata = {3'd0, res_waiting, res_active, res_perm, res_target, res_kind};

endmodule

// ===== design/safa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safa_checker: port-level checks for the slot admission arbiter
// Watches result consistency and the output handshake on the top level's ports.
// ----------------------------------------------------------------------------
module safa_checker
	import safa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	a_perm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11] ==
			((m_tdata[2:0] == KIND_GRANTED) || (m_tdata[2:0] == KIND_REL_PROMOTE))))
		else $error("permission disagrees with result kind");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= KIND_REL_PLAIN))
		else $error("result kind out of range");

	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] <= 4'(SLOT_COUNT_DEF)))
		else $error("active count above capacity");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind slot_admission_fifo_arbiter_top safa_checker u_safa_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
